// ===== design/two_class_ticket_queue_arbiter_unit_macros.svh =====
// Assertion macros for the two-class ticket queue arbiter.
// Included by the top level, the only module that carries concurrent assertions; depends on nothing.
`ifndef TWO_CLASS_TICKET_QUEUE_ARBITER_UNIT_MACROS_SVH
`define TWO_CLASS_TICKET_QUEUE_ARBITER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TQA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TQA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/tqa_pkg.sv =====
// Shared types, codes and constants of the two-class ticket queue arbiter.
// Used by the cell, the ring and the top level; no dependencies.
package tqa_pkg;

  // Default depth of each ticket queue.
  localparam int TQA_QUEUE_DEPTH = 128;

  // Field widths.
  localparam int TQA_TICKET_W = 16;
  localparam int TQA_TIME_W   = 11;
  localparam int TQA_CFG_W    = 4;

  // Reset value of the normal-serve limit and ceiling of the streak count.
  localparam logic [TQA_CFG_W-1:0] TQA_CFG_RESET  = 4'd2;
  localparam logic [TQA_CFG_W-1:0] TQA_STREAK_MAX = 4'd15;

  // Action codes.
  localparam logic [1:0] ACT_ENQ_NORMAL    = 2'd0;
  localparam logic [1:0] ACT_ENQ_PREFERRED = 2'd1;
  localparam logic [1:0] ACT_SERVE         = 2'd2;
  localparam logic [1:0] ACT_SEARCH        = 2'd3;

  // Status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_EMPTY     = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  // Queue classes.
  localparam logic CLASS_NORMAL    = 1'b0;
  localparam logic CLASS_PREFERRED = 1'b1;

  // One stored ticket.
  typedef struct packed {
    logic [TQA_TICKET_W-1:0] ticket;
    logic [TQA_TIME_W-1:0]   arrival_time;
  } tqa_entry_t;

  // Input item.
  typedef struct packed {
    logic [1:0]              action;
    logic [TQA_TIME_W-1:0]   arrival_time;
    logic [TQA_TICKET_W-1:0] search_ticket;
  } tqa_in_item_t;

  // Result item.
  typedef struct packed {
    logic [1:0]              status;
    logic [TQA_TICKET_W-1:0] ticket;
    logic                    queue_class;
    logic [TQA_TIME_W-1:0]   arrival_time_out;
  } tqa_out_item_t;

  // Control of a ring or of a single cell: rotate by one place, or load.
  typedef struct packed {
    logic shift;
    logic wr_en;
  } tqa_ctrl_t;

endpackage

// ===== design/tqa_chan_if.sv =====
// Valid/ready channel interface carrying one item of a given payload type.
// Used with the item types of tqa_pkg; no other dependencies.
interface tqa_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/two_class_ticket_queue_arbiter_unit.sv =====
// Top level of the two-class ticket queue arbiter: control, counters and result register.
// Depends on tqa_pkg, tqa_chan_if, tqa_ring and the assertion macro header.
//
//   port     | direction | carries
//   ---------+-----------+----------------------------------------------------
//   in_chan  | sink      | action, arrival_time, search_ticket
//   out_chan | source    | status, ticket, queue_class, arrival_time_out
//   cfg_*    | write     | normals_before_preferred (4 bits)
//
// Enqueue and serve pass through the deliver state before the next item can be accepted.
// During a search both rings rotate once through every cell.
// Reset is synchronous and clears counters and control; no clearing pass.
// A new item is taken while an earlier result still waits on out_chan; a finished
// result waits in its own stage until the output register is free.
`include "two_class_ticket_queue_arbiter_unit_macros.svh"

module two_class_ticket_queue_arbiter_unit
  import tqa_pkg::*;
#(
  parameter int QUEUE_DEPTH = TQA_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  tqa_chan_if.sink             in_chan,
  tqa_chan_if.source           out_chan,
  input  logic                 cfg_wr_en,
  input  logic [TQA_CFG_W-1:0] cfg_wr_data
);

  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Controller states.
  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_SEARCH  = 2'd1;
  localparam logic [1:0] ST_DELIVER = 2'd2;

  logic [1:0]              state_r, state_nxt;
  logic [CW-1:0]           ncount_r, ncount_nxt;
  logic [CW-1:0]           pcount_r, pcount_nxt;
  logic [TQA_CFG_W-1:0]    streak_r, streak_nxt;
  logic [TQA_TICKET_W-1:0] next_ticket_r, next_ticket_nxt;
  logic [TQA_CFG_W-1:0]    cfg_nbp_r;
  logic [TQA_TICKET_W-1:0] key_r, key_nxt;
  logic [IW-1:0]           step_r, step_nxt;
  logic                    srch_r, srch_nxt;
  logic                    nhit_r, nhit_nxt;
  logic                    phit_r, phit_nxt;
  tqa_entry_t              nfound_r, nfound_nxt;
  tqa_entry_t              pfound_r, pfound_nxt;
  tqa_out_item_t           res_r, res_nxt;
  logic                    out_valid_r, out_valid_nxt;
  tqa_out_item_t           out_data_r, out_data_nxt;

  tqa_ctrl_t     nring_ctrl, pring_ctrl;
  tqa_entry_t    n_head, p_head, wr_entry;
  logic          in_acc, n_full, p_full, prefer, out_free;
  tqa_out_item_t srch_res;
  logic [TQA_TICKET_W-1:0] ticket_adv;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign n_full        = (ncount_r == CW'(QUEUE_DEPTH));
  assign p_full        = (pcount_r == CW'(QUEUE_DEPTH));
  assign prefer        = (streak_r >= cfg_nbp_r) || (ncount_r == '0);
  assign out_free      = !out_valid_r || out_chan.ready;
  assign ticket_adv    = (next_ticket_r == '1) ? TQA_TICKET_W'(1) : next_ticket_r + 1'b1;
  assign wr_entry      = '{ticket: next_ticket_r, arrival_time: in_chan.data.arrival_time};

  // The two queues, each a ring of cells.
  tqa_ring #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_normal_ring (
    .clk       (clk),
    .ring_ctrl (nring_ctrl),
    .wr_idx    (ncount_r[IW-1:0]),
    .wr_entry  (wr_entry),
    .head_entry(n_head)
  );

  tqa_ring #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_preferred_ring (
    .clk       (clk),
    .ring_ctrl (pring_ctrl),
    .wr_idx    (pcount_r[IW-1:0]),
    .wr_entry  (wr_entry),
    .head_entry(p_head)
  );

  // Final search result: a normal hit wins over a preferential one.
  always_comb begin
    srch_res = '{status: STAT_NOT_FOUND, ticket: '0, queue_class: CLASS_NORMAL,
                 arrival_time_out: '0};
    if (nhit_r) begin
      srch_res = '{status: STAT_OK, ticket: nfound_r.ticket, queue_class: CLASS_NORMAL,
                   arrival_time_out: nfound_r.arrival_time};
    end else if (phit_r) begin
      srch_res = '{status: STAT_OK, ticket: pfound_r.ticket, queue_class: CLASS_PREFERRED,
                   arrival_time_out: pfound_r.arrival_time};
    end
  end

  // Controller: enqueue and serve, rotating walk for a search, delivery of the result.
  always_comb begin
    state_nxt       = state_r;
    ncount_nxt      = ncount_r;
    pcount_nxt      = pcount_r;
    streak_nxt      = streak_r;
    next_ticket_nxt = next_ticket_r;
    key_nxt         = key_r;
    step_nxt        = step_r;
    srch_nxt        = srch_r;
    nhit_nxt        = nhit_r;
    phit_nxt        = phit_r;
    nfound_nxt      = nfound_r;
    pfound_nxt      = pfound_r;
    res_nxt         = res_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    nring_ctrl      = '0;
    pring_ctrl      = '0;

    // The output register empties when its item is taken.
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_DELIVER;
          srch_nxt  = 1'b0;
          case (in_chan.data.action)
            ACT_ENQ_NORMAL: begin
              if (n_full) begin
                res_nxt = '{status: STAT_FULL, ticket: '0, queue_class: CLASS_NORMAL,
                            arrival_time_out: '0};
              end else begin
                nring_ctrl.wr_en = 1'b1;
                ncount_nxt       = ncount_r + 1'b1;
                next_ticket_nxt  = ticket_adv;
                res_nxt = '{status: STAT_OK, ticket: next_ticket_r,
                            queue_class: CLASS_NORMAL,
                            arrival_time_out: in_chan.data.arrival_time};
              end
            end
            ACT_ENQ_PREFERRED: begin
              if (p_full) begin
                res_nxt = '{status: STAT_FULL, ticket: '0, queue_class: CLASS_PREFERRED,
                            arrival_time_out: '0};
              end else begin
                pring_ctrl.wr_en = 1'b1;
                pcount_nxt       = pcount_r + 1'b1;
                next_ticket_nxt  = ticket_adv;
                res_nxt = '{status: STAT_OK, ticket: next_ticket_r,
                            queue_class: CLASS_PREFERRED,
                            arrival_time_out: in_chan.data.arrival_time};
              end
            end
            ACT_SERVE: begin
              if ((ncount_r == '0) && (pcount_r == '0)) begin
                res_nxt = '{status: STAT_EMPTY, ticket: '0, queue_class: CLASS_NORMAL,
                            arrival_time_out: '0};
              end else if (prefer && (pcount_r != '0)) begin
                pring_ctrl.shift = 1'b1;
                pcount_nxt       = pcount_r - 1'b1;
                streak_nxt       = '0;
                res_nxt = '{status: STAT_OK, ticket: p_head.ticket,
                            queue_class: CLASS_PREFERRED,
                            arrival_time_out: p_head.arrival_time};
              end else begin
                nring_ctrl.shift = 1'b1;
                ncount_nxt       = ncount_r - 1'b1;
                if (streak_r != TQA_STREAK_MAX) begin
                  streak_nxt = streak_r + 1'b1;
                end
                res_nxt = '{status: STAT_OK, ticket: n_head.ticket,
                            queue_class: CLASS_NORMAL,
                            arrival_time_out: n_head.arrival_time};
              end
            end
            ACT_SEARCH: begin
              state_nxt = ST_SEARCH;
              srch_nxt  = 1'b1;
              key_nxt   = in_chan.data.search_ticket;
              step_nxt  = '0;
              nhit_nxt  = 1'b0;
              phit_nxt  = 1'b0;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_SEARCH: begin
        // Both rings rotate once per cycle; cell 0 shows the entry at this step.
        nring_ctrl.shift = 1'b1;
        pring_ctrl.shift = 1'b1;
        if (!nhit_r && (CW'(step_r) < ncount_r) && (n_head.ticket == key_r)) begin
          nhit_nxt   = 1'b1;
          nfound_nxt = n_head;
        end
        if (!phit_r && (CW'(step_r) < pcount_r) && (p_head.ticket == key_r)) begin
          phit_nxt   = 1'b1;
          pfound_nxt = p_head;
        end
        step_nxt = step_r + 1'b1;
        if (step_r == IW'(QUEUE_DEPTH - 1)) begin
          state_nxt = ST_DELIVER;
        end
      end

      ST_DELIVER: begin
        // Move the finished result into the output register once it is free.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = srch_r ? srch_res : res_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      ncount_r      <= '0;
      pcount_r      <= '0;
      streak_r      <= '0;
      next_ticket_r <= TQA_TICKET_W'(1);
      cfg_nbp_r     <= TQA_CFG_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      ncount_r      <= ncount_nxt;
      pcount_r      <= pcount_nxt;
      streak_r      <= streak_nxt;
      next_ticket_r <= next_ticket_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_nbp_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    key_r      <= key_nxt;
    step_r     <= step_nxt;
    srch_r     <= srch_nxt;
    nhit_r     <= nhit_nxt;
    phit_r     <= phit_nxt;
    nfound_r   <= nfound_nxt;
    pfound_r   <= pfound_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  // Checks on the controller and the queue bookkeeping.
  `TQA_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, state_r != ST_IDLE,
    "block still idle after taking an item")
  `TQA_ASSERT_NEXT(a_search_ends, clk, rst_n,
    (state_r == ST_SEARCH) && (step_r == IW'(QUEUE_DEPTH - 1)), state_r == ST_DELIVER,
    "search walk did not finish after a full rotation")
  `TQA_ASSERT_SAME(a_fail_zero, clk, rst_n,
    out_valid_r && (out_data_r.status != STAT_OK),
    (out_data_r.ticket == '0) && (out_data_r.arrival_time_out == '0),
    "failed result carries a ticket or a time")
  `TQA_ASSERT_NEXT(a_full_no_change, clk, rst_n,
    in_acc && (in_chan.data.action == ACT_ENQ_NORMAL) && n_full,
    $stable(ncount_r) && $stable(next_ticket_r),
    "enqueue into a full queue changed the state")
  `TQA_ASSERT_SAME(a_counts_bounded, clk, rst_n, 1'b1,
    (ncount_r <= CW'(QUEUE_DEPTH)) && (pcount_r <= CW'(QUEUE_DEPTH))
      && (next_ticket_r != '0),
    "queue count beyond depth or ticket counter at zero")

endmodule

// ===== design/tqa_cell.sv =====
// One cell of a ticket ring: holds a single ticket entry.
// Depends on tqa_pkg for the entry and control types.
module tqa_cell
  import tqa_pkg::*;
(
  input  logic       clk,
  input  tqa_ctrl_t  cell_ctrl,
  input  tqa_entry_t next_entry,
  input  tqa_entry_t wr_entry,
  output tqa_entry_t entry
);

  tqa_entry_t entry_r;

  // A load takes the new ticket; a shift takes the neighbour's entry.
  always_ff @(posedge clk) begin
    if (cell_ctrl.wr_en) begin
      entry_r <= wr_entry;
    end else if (cell_ctrl.shift) begin
      entry_r <= next_entry;
    end
  end

  assign entry = entry_r;

endmodule

// ===== design/tqa_ring.sv =====
// A ring of ticket cells forming one queue; outside a search walk the head sits in cell 0.
// Depends on tqa_pkg and tqa_cell.
module tqa_ring
  import tqa_pkg::*;
#(
  parameter int QUEUE_DEPTH = TQA_QUEUE_DEPTH,
  localparam int IW = $clog2(QUEUE_DEPTH)
) (
  input  logic          clk,
  input  tqa_ctrl_t     ring_ctrl,
  input  logic [IW-1:0] wr_idx,
  input  tqa_entry_t    wr_entry,
  output tqa_entry_t    head_entry
);

  tqa_entry_t entry_w [QUEUE_DEPTH];

  // Each cell passes its entry to the cell below it; the head wraps to the last one.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    tqa_ctrl_t cell_ctrl;

    assign cell_ctrl.shift = ring_ctrl.shift;
    assign cell_ctrl.wr_en = ring_ctrl.wr_en && (wr_idx == IW'(i));

    tqa_cell u_cell (
      .clk       (clk),
      .cell_ctrl (cell_ctrl),
      .next_entry(entry_w[(i + 1) % QUEUE_DEPTH]),
      .wr_entry  (wr_entry),
      .entry     (entry_w[i])
    );
  end

  assign head_entry = entry_w[0];

endmodule
